// ===== hw/rtl/scce_pkg.sv =====
// Shared types and constants for the SPI-driven CAN controller command engine.
// Depends on nothing; every other RTL file imports it.
`default_nettype none
package scce_pkg;

  localparam int BUF_BYTES   = 13;
  localparam int MAX_PAYLOAD = 8;
  localparam int REG_DEPTH   = 128;
  localparam logic [7:0] TX_DONE_REG = 8'h30;
  localparam int EXT_BIT     = 3;

  // Command codes seen on the SPI byte stream.
  localparam logic [7:0] CMD_WRITE   = 8'h02;
  localparam logic [7:0] CMD_READ    = 8'h03;
  localparam logic [7:0] CMD_BITMOD  = 8'h05;
  localparam logic [7:0] CMD_LOAD0   = 8'h40;
  localparam logic [7:0] CMD_LOAD1   = 8'h42;
  localparam logic [7:0] CMD_LOAD2   = 8'h44;
  localparam logic [7:0] CMD_SEND0   = 8'h81;
  localparam logic [7:0] CMD_SEND1   = 8'h82;
  localparam logic [7:0] CMD_SEND2   = 8'h84;
  localparam logic [7:0] CMD_SENDALL = 8'h87;
  localparam logic [7:0] CMD_RXREAD0 = 8'h90;
  localparam logic [7:0] CMD_RXREAD1 = 8'h94;
  localparam logic [7:0] CMD_STATUS  = 8'hA0;
  localparam logic [7:0] CMD_ABORT   = 8'hC0;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_READ    = 4'd1,
    MODE_WRITE   = 4'd2,
    MODE_BITMOD  = 4'd3,
    MODE_LOAD0   = 4'd4,
    MODE_LOAD1   = 4'd5,
    MODE_LOAD2   = 4'd6,
    MODE_SEND0   = 4'd7,
    MODE_SEND1   = 4'd8,
    MODE_SEND2   = 4'd9,
    MODE_SENDALL = 4'd10,
    MODE_RX0     = 4'd11,
    MODE_RX1     = 4'd12,
    MODE_STATUS  = 4'd13
  } mode_t;

  // One buffer image: 4 ID bytes, length, 8 payload bytes; byte k at [k].
  typedef logic [BUF_BYTES-1:0][7:0] buf_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  mosi_byte;
    logic [10:0] rx_ident;
    logic [3:0]  rx_count;
    logic [63:0] rx_bytes;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  miso_byte;
    logic        frame_sent;
    logic [28:0] sent_ident;
    logic [3:0]  sent_count;
    logic [63:0] sent_bytes;
    logic        rx_dropped;
  } out_item_t;

  // Classified word handed from the front end to the execution side.
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       cmd_hit;
    mode_t      cmd_mode;
    buf_t       rx_image;
  } cmd_t;

  function automatic logic [3:0] clamp_len(input logic [7:0] v);
    clamp_len = (v > 8'(MAX_PAYLOAD)) ? 4'(MAX_PAYLOAD) : v[3:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/scce_front.sv =====
// Front end: accepts input words, decodes command bytes and builds the
// receive-buffer image of incoming frames. Depends on scce_pkg.
`default_nettype none
module scce_front #(
  parameter int TX_BUFFERS = 3,
  parameter int RX_BUFFERS = 2
) (
  input  wire                 in_valid,
  input  scce_pkg::in_item_t  in_data,
  output logic                in_stall,
  input  wire                 q_full,
  output logic                push_valid,
  output scce_pkg::cmd_t      push_item
);
  import scce_pkg::*;

  logic [3:0] len;

  assign in_stall   = q_full;
  assign push_valid = in_valid && !q_full;

  always_comb begin
    push_item          = '0;
    push_item.kind     = in_data.kind;
    push_item.data     = in_data.mosi_byte;
    push_item.cmd_mode = MODE_IDLE;
    push_item.cmd_hit  = 1'b0;
    case (in_data.mosi_byte)
      CMD_WRITE: begin
        push_item.cmd_hit = 1'b1; push_item.cmd_mode = MODE_WRITE;
      end
      CMD_READ: begin
        push_item.cmd_hit = 1'b1; push_item.cmd_mode = MODE_READ;
      end
      CMD_BITMOD: begin
        push_item.cmd_hit = 1'b1; push_item.cmd_mode = MODE_BITMOD;
      end
      CMD_LOAD0: begin
        push_item.cmd_hit = 1'b1; push_item.cmd_mode = MODE_LOAD0;
      end
      CMD_LOAD1: begin
        push_item.cmd_hit = (TX_BUFFERS > 1); push_item.cmd_mode = MODE_LOAD1;
      end
      CMD_LOAD2: begin
        push_item.cmd_hit = (TX_BUFFERS > 2); push_item.cmd_mode = MODE_LOAD2;
      end
      CMD_SEND0: begin
        push_item.cmd_hit = 1'b1; push_item.cmd_mode = MODE_SEND0;
      end
      CMD_SEND1: begin
        push_item.cmd_hit = (TX_BUFFERS > 1); push_item.cmd_mode = MODE_SEND1;
      end
      CMD_SEND2: begin
        push_item.cmd_hit = (TX_BUFFERS > 2); push_item.cmd_mode = MODE_SEND2;
      end
      CMD_SENDALL: begin
        push_item.cmd_hit = 1'b1; push_item.cmd_mode = MODE_SENDALL;
      end
      CMD_RXREAD0: begin
        push_item.cmd_hit = 1'b1; push_item.cmd_mode = MODE_RX0;
      end
      CMD_RXREAD1: begin
        push_item.cmd_hit = (RX_BUFFERS > 1); push_item.cmd_mode = MODE_RX1;
      end
      CMD_STATUS: begin
        push_item.cmd_hit = 1'b1; push_item.cmd_mode = MODE_STATUS;
      end
      CMD_ABORT: begin
        push_item.cmd_hit = 1'b1; push_item.cmd_mode = MODE_IDLE;
      end
      default: begin
        push_item.cmd_hit = 1'b0;
      end
    endcase

    // Receive image: standard ID packed as SIDH/SIDL, length clamped.
    len = clamp_len({4'b0, in_data.rx_count});
    push_item.rx_image[0] = in_data.rx_ident[10:3];
    push_item.rx_image[1] = {in_data.rx_ident[2:0], 5'b0};
    push_item.rx_image[4] = {4'b0, len};
    for (int k = 0; k < MAX_PAYLOAD; k++) begin
      if (4'(k) < len) begin
        push_item.rx_image[5 + k] = in_data.rx_bytes[8*k +: 8];
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/scce_queue.sv =====
// Two-entry queue that decouples the front end from the execution side.
// Depends on scce_pkg.
`default_nettype none
module scce_queue (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push_valid,
  input  scce_pkg::cmd_t   push_item,
  output logic             q_full,
  input  wire              q_pop,
  output logic             q_valid,
  output scce_pkg::cmd_t   q_item
);
  import scce_pkg::*;

  cmd_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_valid;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    cnt_nxt    = cnt_r + 2'(push_valid) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/scce_back.sv =====
// Execution side: command state machine, register file, transmit and receive
// buffers, and the result register. Depends on scce_pkg.
`default_nettype none
module scce_back #(
  parameter int LAST_REGISTER = 113,
  parameter int TX_BUFFERS    = 3,
  parameter int RX_BUFFERS    = 2
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_valid,
  input  scce_pkg::cmd_t       q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire                  out_stall,
  output scce_pkg::out_item_t  out_data
);
  import scce_pkg::*;

  localparam int TXW = (TX_BUFFERS > 1) ? $clog2(TX_BUFFERS) : 1;
  localparam int RXW = (RX_BUFFERS > 1) ? $clog2(RX_BUFFERS) : 1;

  mode_t       mode_r, mode_nxt;
  logic [7:0]  rp_r, rp_nxt;
  logic        rv_r, rv_nxt;
  logic [7:0]  wp_r, wp_nxt;
  logic        wv_r, wv_nxt;
  logic [1:0]  bp_r, bp_nxt;
  logic [7:0]  ba_r, ba_nxt;
  logic [7:0]  bm_r, bm_nxt;
  logic [1:0]  lph_r, lph_nxt;
  logic [3:0]  lp_r, lp_nxt;
  logic [3:0]  rxp_r, rxp_nxt;
  logic [1:0]  full_r, full_nxt;
  buf_t        txb_r [TX_BUFFERS];
  buf_t        txb_nxt [TX_BUFFERS];
  buf_t        rxb_r [RX_BUFFERS];
  buf_t        rxb_nxt [RX_BUFFERS];
  out_item_t   out_r, out_nxt;
  logic        out_valid_r;

  logic [7:0]  rf_mem [REG_DEPTH];
  logic [REG_DEPTH-1:0] rf_vld_r;
  logic [7:0]  rd_r;
  logic        we;
  logic [6:0]  waddr;
  logic [7:0]  wdata;
  logic [6:0]  raddr;

  function automatic logic reg_ok(input logic [7:0] a);
    reg_ok = (a <= 8'(LAST_REGISTER)) && !a[7];
  endfunction

  assign q_pop     = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    logic       found;
    logic [1:0] bidx;
    logic [3:0] n;
    logic [3:0] inc;
    logic [10:0] id11;
    buf_t       p;
    logic [7:0] b;

    mode_nxt = mode_r;  rp_nxt = rp_r;  rv_nxt = rv_r;
    wp_nxt = wp_r;      wv_nxt = wv_r;  bp_nxt = bp_r;
    ba_nxt = ba_r;      bm_nxt = bm_r;  lph_nxt = lph_r;
    lp_nxt = lp_r;      rxp_nxt = rxp_r; full_nxt = full_r;
    txb_nxt = txb_r;    rxb_nxt = rxb_r;
    out_nxt = '0;
    we = 1'b0;  waddr = '0;  wdata = '0;
    found = 1'b0;  bidx = '0;  n = '0;  inc = '0;  id11 = '0;  p = '0;
    b = q_item.data;

    if (q_pop) begin
      if (q_item.kind) begin
        // Incoming frame: first empty receive buffer, or dropped.
        for (int i = 0; i < RX_BUFFERS; i++) begin
          if (!found && !full_r[i]) begin
            rxb_nxt[i]  = q_item.rx_image;
            full_nxt[i] = 1'b1;
            found       = 1'b1;
          end
        end
        out_nxt.rx_dropped = !found;
      end else begin
        case (mode_r)
          MODE_IDLE: begin
            if (q_item.cmd_hit) mode_nxt = q_item.cmd_mode;
          end
          MODE_READ: begin
            if (!rv_r) begin
              rp_nxt = b;
              rv_nxt = 1'b1;
            end else if (b != 8'd0) begin
              rv_nxt = 1'b0;
              if (q_item.cmd_hit) mode_nxt = q_item.cmd_mode;
            end else begin
              out_nxt.miso_byte = reg_ok(rp_r) ? rd_r : 8'd0;
              rp_nxt = rp_r + 8'd1;
            end
          end
          MODE_WRITE: begin
            if (!wv_r) begin
              wp_nxt = b;
              wv_nxt = 1'b1;
            end else begin
              we       = reg_ok(wp_r);
              waddr    = wp_r[6:0];
              wdata    = b;
              wv_nxt   = 1'b0;
              mode_nxt = MODE_IDLE;
            end
          end
          MODE_BITMOD: begin
            if (bp_r == 2'd0) begin
              ba_nxt = b;
              bp_nxt = 2'd1;
            end else if (bp_r == 2'd1) begin
              bm_nxt = b;
              bp_nxt = 2'd2;
            end else begin
              we       = reg_ok(ba_r);
              waddr    = ba_r[6:0];
              wdata    = (rd_r & ~bm_r) | (b & bm_r);
              bp_nxt   = 2'd0;
              mode_nxt = MODE_IDLE;
            end
          end
          MODE_LOAD0, MODE_LOAD1, MODE_LOAD2: begin
            bidx = (mode_r == MODE_LOAD0) ? 2'd0 : (mode_r == MODE_LOAD1) ? 2'd1 : 2'd2;
            if (32'(bidx) < TX_BUFFERS) begin
              inc = lp_r + 4'd1;
              if (lph_r == 2'd0) begin
                txb_nxt[bidx[TXW-1:0]][{2'b0, lp_r[1:0]}] = b;
                lp_nxt = inc;
                if (inc >= 4'd4) begin
                  lp_nxt  = 4'd0;
                  lph_nxt = 2'd1;
                end
              end else if (lph_r == 2'd1) begin
                n = clamp_len(b);
                txb_nxt[bidx[TXW-1:0]][4] = {4'b0, n};
                lp_nxt = 4'd0;
                if (n == 4'd0) begin
                  lph_nxt  = 2'd0;
                  mode_nxt = MODE_IDLE;
                end else begin
                  lph_nxt = 2'd2;
                end
              end else begin
                if (lp_r < 4'(MAX_PAYLOAD)) begin
                  txb_nxt[bidx[TXW-1:0]][4'd5 + lp_r] = b;
                end
                lp_nxt = inc;
                if ({4'b0, inc} >= txb_r[bidx[TXW-1:0]][4] || inc >= 4'(MAX_PAYLOAD)) begin
                  lp_nxt   = 4'd0;
                  lph_nxt  = 2'd0;
                  mode_nxt = MODE_IDLE;
                end
              end
            end else begin
              mode_nxt = MODE_IDLE;
            end
          end
          MODE_SEND0, MODE_SEND1, MODE_SEND2, MODE_SENDALL: begin
            bidx = (mode_r == MODE_SEND1) ? 2'd1 : (mode_r == MODE_SEND2) ? 2'd2 : 2'd0;
            if (32'(bidx) < TX_BUFFERS) begin
              p    = txb_r[bidx[TXW-1:0]];
              id11 = {p[0], p[1][7:5]};
              n    = clamp_len(p[4]);
              out_nxt.frame_sent = 1'b1;
              out_nxt.sent_ident = p[1][EXT_BIT] ? {id11, p[1][1:0], p[2], p[3]}
                                                 : {18'b0, id11};
              out_nxt.sent_count = n;
              for (int k = 0; k < MAX_PAYLOAD; k++) begin
                if (4'(k) < n) out_nxt.sent_bytes[8*k +: 8] = p[5 + k];
              end
              we       = 1'b1;
              waddr    = TX_DONE_REG[6:0];
              wdata    = 8'd0;
              rv_nxt   = 1'b0;
              mode_nxt = MODE_READ;
            end else begin
              mode_nxt = MODE_IDLE;
            end
          end
          MODE_RX0, MODE_RX1: begin
            bidx = (mode_r == MODE_RX0) ? 2'd0 : 2'd1;
            if (32'(bidx) < RX_BUFFERS) begin
              p   = rxb_r[bidx[RXW-1:0]];
              n   = clamp_len(p[4]);
              inc = rxp_r + 4'd1;
              if (rxp_r < 4'(BUF_BYTES)) out_nxt.miso_byte = p[rxp_r];
              rxp_nxt = inc;
              if ({1'b0, inc} > ({1'b0, n} + 5'd4) || inc >= 4'(BUF_BYTES)) begin
                rxp_nxt        = 4'd0;
                mode_nxt       = MODE_IDLE;
                full_nxt[bidx[0]] = 1'b0;
              end
            end else begin
              mode_nxt = MODE_IDLE;
            end
          end
          MODE_STATUS: begin
            out_nxt.miso_byte = {6'b0, full_r};
            mode_nxt = MODE_IDLE;
          end
          default: begin
            mode_nxt = MODE_IDLE;
          end
        endcase
      end
    end

    // Prefetch the register the next read or bit modify will need.
    raddr = (mode_nxt == MODE_BITMOD) ? ba_nxt[6:0] : rp_nxt[6:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      rp_r <= '0;  rv_r <= 1'b0;  wp_r <= '0;  wv_r <= 1'b0;
      bp_r <= '0;  ba_r <= '0;    bm_r <= '0;
      lph_r <= '0; lp_r <= '0;    rxp_r <= '0; full_r <= '0;
      for (int i = 0; i < TX_BUFFERS; i++) txb_r[i] <= '0;
      for (int i = 0; i < RX_BUFFERS; i++) rxb_r[i] <= '0;
      rf_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      rp_r <= rp_nxt;  rv_r <= rv_nxt;  wp_r <= wp_nxt;  wv_r <= wv_nxt;
      bp_r <= bp_nxt;  ba_r <= ba_nxt;  bm_r <= bm_nxt;
      lph_r <= lph_nxt; lp_r <= lp_nxt; rxp_r <= rxp_nxt; full_r <= full_nxt;
      txb_r <= txb_nxt;
      rxb_r <= rxb_nxt;
      if (we) rf_vld_r[waddr] <= 1'b1;
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Register file storage with a registered read and write-through bypass.
  always_ff @(posedge clk) begin
    if (we) rf_mem[waddr] <= wdata;
    if (we && waddr == raddr) begin
      rd_r <= wdata;
    end else begin
      rd_r <= rf_vld_r[raddr] ? rf_mem[raddr] : 8'd0;
    end
    if (q_pop) out_r <= out_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/spi_can_controller_command_engine_core.sv =====
// A word accepted by the front end is written into the queue, then executed
// into the result register; a stalled result register keeps it queued.
// Throughput: one word per cycle while the result register is not stalled.
// Reset (rst_n low, synchronous) empties the queue and result register, returns
// the command engine to idle and clears all buffers and register-file valid bits.
`default_nettype none
module spi_can_controller_command_engine_core #(
  parameter int LAST_REGISTER = 113,
  parameter int TX_BUFFERS    = 3,
  parameter int RX_BUFFERS    = 2
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  scce_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output scce_pkg::out_item_t  out_data
);
  import scce_pkg::*;

  // The front end only classifies; it stalls solely when the queue is full.
  logic  q_full;
  logic  push_valid;
  cmd_t  push_item;
  logic  q_valid;
  logic  q_pop;
  cmd_t  q_item;

  scce_front #(
    .TX_BUFFERS(TX_BUFFERS),
    .RX_BUFFERS(RX_BUFFERS)
  ) u_front (
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  // The queue lets the back end hold while the result register is stalled.
  scce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .q_full     (q_full),
    .q_pop      (q_pop),
    .q_valid    (q_valid),
    .q_item     (q_item)
  );

  // The back end executes one word per cycle whenever its result slot frees.
  scce_back #(
    .LAST_REGISTER(LAST_REGISTER),
    .TX_BUFFERS   (TX_BUFFERS),
    .RX_BUFFERS   (RX_BUFFERS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // An accepted word is in the queue on the next cycle.
  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> q_valid)
    else $error("accepted word did not reach the queue");

  // Executing a word always produces a result on the next cycle.
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid)
    else $error("executed word produced no result");

  // Nothing executes while a stalled result still waits.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !q_pop)
    else $error("result register overwritten while stalled");

endmodule
`default_nettype wire
